>>> rtl/abdd_pkg.sv
// ----------------------------------------------------------------------------
// abdd_pkg
// Types, constants and elaboration-time helpers for the anchor-box decoder.
// ----------------------------------------------------------------------------
package abdd_pkg;

   localparam int SIG_DEPTH_DEFAULT = 1024;

   localparam logic [7:0]  NUM_CLASSES_RST = 8'd80;
   localparam logic [15:0] BOX_THR_RST     = 16'd32768;
   localparam logic [15:0] CLASS_THR_RST   = 16'd32768;
   localparam logic [15:0] RATIO_RST       = 16'd256;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_CLASSES = 3'd0,
      REG_BOX_THR     = 3'd1,
      REG_CLASS_THR   = 3'd2,
      REG_RATIO_W     = 3'd3,
      REG_RATIO_H     = 3'd4
   } csr_reg_type;

   localparam logic [8:0] POS_MAX    = 9'd511;
   localparam logic [8:0] POS_OBJ    = 9'd4;
   localparam logic [8:0] POS_CLASS0 = 9'd5;
   localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;

   // one finished cell row handed from the front to the back
   typedef struct packed {
      logic signed [15:0] box_x;
      logic signed [15:0] box_y;
      logic signed [15:0] box_w;
      logic signed [15:0] box_h;
      logic signed [15:0] obj;
      logic signed [15:0] best;
      logic [7:0]         best_pos;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [2:0]         shift;
      logic [9:0]         anc_wid;
      logic [9:0]         anc_hgt;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_EDGE,
      ST_OUT
   } back_state_type;

   localparam logic [63:0] ONE_Q32    = 64'd4294967296;
   localparam logic [63:0] E_NEG1_Q32 = 64'd1580030169;

   // shift-subtract divide, used only when building the sigmoid table
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [11:0] t);
      logic [63:0] r;
      logic [63:0] n;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      r = 64'(t[7:0]);
      n = 64'(t[11:8]);
      term = ONE_Q32;
      sum  = ONE_Q32;
      for (int k = 1; k <= 10; k++) begin
         term = udiv(term * r, 64'(256 * k));
         if (k % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      e = sum;
      for (int k = 0; k < 8; k++) begin
         if (64'(k) < n) e = (e * E_NEG1_Q32 + 64'd2147483648) >> 32;
      end
      return e;
   endfunction

   function automatic logic [15:0] sig_entry(input int i, input int depth);
      int          c;
      logic [11:0] mag;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] p;
      c   = -2048 + int'(udiv(64'(i * 4096 + 2048), 64'(depth)));
      mag = (c < 0) ? 12'(-c) : 12'(c);
      e   = exp_neg(mag);
      den = ONE_Q32 + e;
      num = (c >= 0) ? (ONE_Q32 << 16) : (e << 16);
      p   = udiv(num + (den >> 1), den);
      return (p > 64'd65535) ? 16'hFFFF : p[15:0];
   endfunction

endpackage

>>> rtl/abdd_if.sv
// ----------------------------------------------------------------------------
// abdd channel interfaces
// Input, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface abdd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] raw_logit;
   logic [7:0]         grid_col;
   logic [7:0]         grid_row;
   logic [2:0]         stride_shift;
   logic [9:0]         anchor_width;
   logic [9:0]         anchor_height;
   logic               last_in_row;
   modport source (output valid, raw_logit, grid_col, grid_row, stride_shift,
                   anchor_width, anchor_height, last_in_row, input ready);
   modport sink   (input valid, raw_logit, grid_col, grid_row, stride_shift,
                   anchor_width, anchor_height, last_in_row, output ready);
endinterface

interface abdd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         class_index;
   logic [15:0]        confidence;
   logic signed [15:0] box_left;
   logic signed [15:0] box_top;
   logic [15:0]        box_width;
   logic [15:0]        box_height;
   modport source (output valid, class_index, confidence, box_left, box_top,
                   box_width, box_height, input ready);
   modport sink   (input valid, class_index, confidence, box_left, box_top,
                   box_width, box_height, output ready);
endinterface

interface abdd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/anchor_box_detection_decode_unit.sv
// Path: a finished row's job passes the job queue, then LOOK and CHECK in the
// back, and with a detection MUL1-MUL3, EDGE and OUT. Throughput: one logit per
// cycle within a row unless the job queue is full; a row end holds the back
// longer with a detection, plus rsp stalls; a 2-entry queue absorbs short rows.
// Reset: synchronous, active high; row state, queue and registers return to
// their defaults at once, no clearing pass.
// ----------------------------------------------------------------------------
// anchor_box_detection_decode_unit
// Detection-head decoder: row classification in front, sigmoid and box decode
// in back, joined by a job queue.
// ----------------------------------------------------------------------------
module anchor_box_detection_decode_unit #(
   parameter int SIG_DEPTH = abdd_pkg::SIG_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   abdd_req_if.sink   req,
   abdd_rsp_if.source rsp,
   abdd_csr_if.sink   csr
);
   import abdd_pkg::*;

   logic [7:0]  num_classes_ff;
   logic [15:0] box_thr_ff, class_thr_ff, ratio_w_ff, ratio_h_ff;
   logic        push, push_ready, pop_valid, pop;
   job_type     push_job, pop_job;
   logic [1:0]  q_count;
   logic [8:0]  position;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= NUM_CLASSES_RST;
         box_thr_ff     <= BOX_THR_RST;
         class_thr_ff   <= CLASS_THR_RST;
         ratio_w_ff     <= RATIO_RST;
         ratio_h_ff     <= RATIO_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_NUM_CLASSES: num_classes_ff <= csr.data[7:0];
            REG_BOX_THR:     box_thr_ff     <= csr.data;
            REG_CLASS_THR:   class_thr_ff   <= csr.data;
            REG_RATIO_W:     ratio_w_ff     <= csr.data;
            REG_RATIO_H:     ratio_h_ff     <= csr.data;
            default: ;
         endcase
      end
   end

   abdd_front u_front (
      .clock, .reset, .req,
      .num_classes (num_classes_ff),
      .push, .push_job, .push_ready, .position
   );

   abdd_queue u_queue (
      .clock, .reset, .push, .push_job, .push_ready,
      .pop_valid, .pop_job, .pop, .count (q_count)
   );

   abdd_back #(.SIG_DEPTH(SIG_DEPTH)) u_back (
      .clock, .reset,
      .job_valid       (pop_valid),
      .job_in          (pop_job),
      .job_pop         (pop),
      .box_threshold   (box_thr_ff),
      .class_threshold (class_thr_ff),
      .ratio_w         (ratio_w_ff),
      .ratio_h         (ratio_h_ff),
      .rsp
   );

`ifndef SYNTHESIS
   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.last_in_row |=> position == 9'd0)
      else $error("row position not cleared at row end");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !req.last_in_row && position != POS_MAX
      |=> position == $past(position) + 9'd1)
      else $error("row position did not advance");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("job queue overfilled");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_count == 2'd2 |-> !req.ready)
      else $error("input taken while job queue full");
`endif

endmodule

>>> rtl/abdd_front.sv
// ----------------------------------------------------------------------------
// abdd_front
// Places each logit in its cell row, keeps box/objectness logits and the
// running best class, and pushes a job at the row's last element.
// ----------------------------------------------------------------------------
module abdd_front (
   input  logic              clock,
   input  logic              reset,
   abdd_req_if.sink          req,
   input  logic [7:0]        num_classes,
   output logic              push,
   output abdd_pkg::job_type push_job,
   input  logic              push_ready,
   output logic [8:0]        position
);
   import abdd_pkg::*;

   logic [8:0]         pos_ff, pos_in;
   logic signed [15:0] box_ff [4];
   logic signed [15:0] box_u  [4];
   logic signed [15:0] obj_ff, obj_u;
   logic signed [15:0] best_ff, best_u, best_in;
   logic [7:0]         bpos_ff, bpos_u, bpos_in;
   logic [8:0]         cls_pos;
   logic               accept;

   assign req.ready = push_ready;
   assign accept    = req.valid & req.ready;
   assign cls_pos   = pos_ff - POS_CLASS0;
   assign position  = pos_ff;

   always_comb begin
      box_u  = box_ff;
      obj_u  = obj_ff;
      best_u = best_ff;
      bpos_u = bpos_ff;
      pos_in = pos_ff;
      if (pos_ff < POS_OBJ) begin
         box_u[pos_ff[1:0]] = req.raw_logit;
      end else if (pos_ff == POS_OBJ) begin
         obj_u = req.raw_logit;
      end else if (cls_pos < {1'b0, num_classes} && req.raw_logit > best_ff) begin
         best_u = req.raw_logit;
         bpos_u = cls_pos[7:0];
      end
      if (pos_ff != POS_MAX) pos_in = pos_ff + 9'd1;
      best_in = best_u;
      bpos_in = bpos_u;
      if (req.last_in_row) begin
         pos_in  = '0;
         best_in = LOGIT_MIN;
         bpos_in = '0;
      end
   end

   assign push = accept & req.last_in_row;
   always_comb begin
      push_job.box_x    = box_u[0];
      push_job.box_y    = box_u[1];
      push_job.box_w    = box_u[2];
      push_job.box_h    = box_u[3];
      push_job.obj      = obj_u;
      push_job.best     = best_u;
      push_job.best_pos = bpos_u;
      push_job.col      = req.grid_col;
      push_job.row      = req.grid_row;
      push_job.shift    = req.stride_shift;
      push_job.anc_wid  = req.anchor_width;
      push_job.anc_hgt  = req.anchor_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         best_ff <= LOGIT_MIN;
         bpos_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         best_ff <= best_in;
         bpos_ff <= bpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         box_ff <= box_u;
         obj_ff <= obj_u;
      end
   end

endmodule

>>> rtl/abdd_queue.sv
// ----------------------------------------------------------------------------
// abdd_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module abdd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  abdd_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output abdd_pkg::job_type pop_job,
   input  logic              pop,
   output logic [1:0]        count
);
   import abdd_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;
   assign count      = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

>>> rtl/abdd_back.sv
// ----------------------------------------------------------------------------
// abdd_back
// Looks up the six sigmoids of a job in the table ROM, applies thresholds
// and decodes the box into image pixels over a short multiply sequence.
// ----------------------------------------------------------------------------
module abdd_back #(
   parameter int SIG_DEPTH = abdd_pkg::SIG_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  abdd_pkg::job_type job_in,
   output logic              job_pop,
   input  logic [15:0]       box_threshold,
   input  logic [15:0]       class_threshold,
   input  logic [15:0]       ratio_w,
   input  logic [15:0]       ratio_h,
   abdd_rsp_if.source        rsp
);
   import abdd_pkg::*;

   localparam int IW = $clog2(SIG_DEPTH);
   localparam int DW = $clog2(SIG_DEPTH + 1);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [2:0]     cnt_ff;
   logic [15:0]    rom_w [SIG_DEPTH];
   logic [15:0]    rom_q_ff;
   logic [15:0]    sig_ff [6];
   logic signed [15:0] sel_logit, clamped;
   logic [11:0]    uoff;
   logic [11+DW:0] scaled;
   logic [IW-1:0]  addr;
   logic           pass;

   logic [15:0]        conf_ff;
   logic [17:0]        sqx_ff, sqy_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic [27:0]        wx_ff, wy_ff;
   logic signed [18:0] lix_ff, liy_ff;
   logic [15:0]        szx_ff, szy_ff;
   logic signed [35:0] prx_ff, pry_ff;
   logic [7:0]         cls_o_ff;
   logic [15:0]        conf_o_ff, w_o_ff, h_o_ff;
   logic signed [15:0] l_o_ff, t_o_ff;

   for (genvar g = 0; g < SIG_DEPTH; g++) begin : g_rom
      localparam logic [15:0] Entry = sig_entry(g, SIG_DEPTH);
      assign rom_w[g] = Entry;
   end

   always_comb begin
      unique case (cnt_ff)
         3'd0:    sel_logit = job_ff.obj;
         3'd1:    sel_logit = job_ff.best;
         3'd2:    sel_logit = job_ff.box_x;
         3'd3:    sel_logit = job_ff.box_y;
         3'd4:    sel_logit = job_ff.box_w;
         default: sel_logit = job_ff.box_h;
      endcase
      if (sel_logit < -16'sd2048)     clamped = -16'sd2048;
      else if (sel_logit > 16'sd2047) clamped = 16'sd2047;
      else                            clamped = sel_logit;
      uoff   = 12'(clamped + 16'sd2048);
      scaled = (12+DW)'(uoff) * (12+DW)'(SIG_DEPTH);
      addr   = scaled[12 +: IW];
   end

   always_ff @(posedge clock) rom_q_ff <= rom_w[addr];

   assign pass = sig_ff[0] >= box_threshold && sig_ff[1] >= class_threshold;

   always_comb begin
      state_in = state_ff;
      job_pop  = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (job_valid) begin
            job_pop  = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK:  if (cnt_ff == 3'd6) state_in = ST_CHECK;
         ST_CHECK: state_in = pass ? ST_MUL1 : ST_IDLE;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_EDGE;
         ST_EDGE:  state_in = ST_OUT;
         ST_OUT:   if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOOK) cnt_ff <= cnt_ff + 3'd1;
         else                     cnt_ff <= '0;
      end
   end

   function automatic logic signed [33:0] centre(input logic [15:0] s, input logic [7:0] grid,
                                                input logic [2:0] sh);
      logic signed [33:0] base;
      base = $signed({10'd0, grid, 16'd0}) + $signed({17'd0, s, 1'b0}) - 34'sd32768;
      return base <<< sh;
   endfunction

   function automatic logic [17:0] square(input logic [15:0] s);
      logic [33:0] t2;
      t2 = 34'({s, 1'b0}) * 34'({s, 1'b0});
      return 18'((35'(t2) + 35'd32768) >> 16);
   endfunction

   function automatic logic signed [18:0] edge_int(input logic signed [33:0] c,
                                                  input logic [27:0] w);
      logic signed [35:0] d;
      d = ($signed({c[33], c, 1'b0})) - $signed({8'd0, w});
      if (d < 0) d = d + 36'sd131071;
      return 19'(d >>> 17);
   endfunction

   function automatic logic [15:0] size_px(input logic [27:0] w, input logic [15:0] r);
      logic [43:0] p;
      p = 44'(w) * 44'(r);
      return (p[43:24] > 20'd65535) ? 16'hFFFF : p[39:24];
   endfunction

   function automatic logic signed [15:0] edge_px(input logic signed [35:0] pr);
      logic signed [37:0] n;
      n = $signed({pr[35], pr, 1'b0}) + 38'sd256;
      if (n < 0) n = n + 38'sd511;
      n = n >>> 9;
      if (n > 38'sd32767)       return 16'sh7FFF;
      else if (n < -38'sd32768) return 16'sh8000;
      else                      return n[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job_in;
      // table data is registered, arriving in the cycle after its address
      if (state_ff == ST_LOOK && cnt_ff != 3'd0) sig_ff[cnt_ff - 3'd1] <= rom_q_ff;
      if (state_ff == ST_CHECK) begin
         conf_ff <= 16'((32'(sig_ff[1]) * 32'(sig_ff[0]) + 32'd32768) >> 16);
         sqx_ff  <= square(sig_ff[4]);
         sqy_ff  <= square(sig_ff[5]);
         cx_ff   <= centre(sig_ff[2], job_ff.col, job_ff.shift);
         cy_ff   <= centre(sig_ff[3], job_ff.row, job_ff.shift);
      end
      if (state_ff == ST_MUL1) begin
         wx_ff <= 28'(sqx_ff) * 28'(job_ff.anc_wid);
         wy_ff <= 28'(sqy_ff) * 28'(job_ff.anc_hgt);
      end
      if (state_ff == ST_MUL2) begin
         lix_ff <= edge_int(cx_ff, wx_ff);
         liy_ff <= edge_int(cy_ff, wy_ff);
         szx_ff <= size_px(wx_ff, ratio_w);
         szy_ff <= size_px(wy_ff, ratio_h);
      end
      if (state_ff == ST_MUL3) begin
         prx_ff <= 36'(lix_ff) * 36'($signed({1'b0, ratio_w}));
         pry_ff <= 36'(liy_ff) * 36'($signed({1'b0, ratio_h}));
      end
      if (state_ff == ST_EDGE) begin
         cls_o_ff  <= job_ff.best_pos;
         conf_o_ff <= conf_ff;
         l_o_ff    <= edge_px(prx_ff);
         t_o_ff    <= edge_px(pry_ff);
         w_o_ff    <= szx_ff;
         h_o_ff    <= szy_ff;
      end
   end

   assign rsp.valid       = state_ff == ST_OUT;
   assign rsp.class_index = cls_o_ff;
   assign rsp.confidence  = conf_o_ff;
   assign rsp.box_left    = l_o_ff;
   assign rsp.box_top     = t_o_ff;
   assign rsp.box_width   = w_o_ff;
   assign rsp.box_height  = h_o_ff;

endmodule
